### design/fbqg_pkg.sv
// ---------------------------------------------------------------------------
// Frame budget quality governor package
// Shared types, register indexes and constants of the governor.
// ---------------------------------------------------------------------------
`default_nettype none

package fbqg_pkg;

  // Full quality in Q12
  localparam logic [12:0] FULL_Q = 13'd4096;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOCATION_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PINNED_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTORE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_RATE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_FLOOR    = 3'd5;

  // Input transaction
  typedef struct packed {
    logic [15:0] measured_time;
    logic [15:0] elapsed_time;
  } in_t;

  // Output transaction, one per class
  typedef struct packed {
    logic [2:0]  class_index;
    logic [12:0] spawn_gain;
    logic [13:0] simulation_rate;
    logic [12:0] cap_gain;
    logic [1:0]  collision_tier;
    logic [1:0]  feature_tier;
    logic [1:0]  detail_bias;
    logic        sorting_on;
    logic [6:0]  changed_mask;
    logic [1:0]  status;
    logic [3:0]  reduced_class;
    logic        last;
  } out_t;

  // Lever values derived from one quality
  typedef struct packed {
    logic [12:0] spawn_gain;
    logic [13:0] simulation_rate;
    logic [12:0] cap_gain;
    logic [1:0]  collision_tier;
    logic [1:0]  feature_tier;
    logic [1:0]  detail_bias;
    logic        sorting_on;
  } levers_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_STEP,
    ST_MUL_RED,
    ST_MUL_RES,
    ST_DECIDE,
    ST_SEARCH,
    ST_MASK_OLD,
    ST_MASK_NEW,
    ST_SCAN,
    ST_LOAD,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

### design/fbqg_levers.sv
// ---------------------------------------------------------------------------
// Quality lever unit
// Maps one Q12 quality to spawn, rate and cap scales, tiers, LOD bias and
// the sorting flag.
// ---------------------------------------------------------------------------
`default_nettype none

module fbqg_levers (
  input  wire logic [12:0]       quality_i,
  output fbqg_pkg::levers_t      levers_o
);

  localparam logic [24:0] SPAWN_SPAN = 25'd3482;
  localparam logic [25:0] RATE_SPAN  = 26'd13312;
  localparam logic [23:0] CAP_SPAN   = 24'd3277;

  logic [24:0] spawn_p;
  logic [25:0] rate_p;
  logic [23:0] cap_p;
  logic [12:0] lost_q;
  logic [13:0] lod_p;

  // Interpolate with half-up rounding
  assign spawn_p = 25'(quality_i) * SPAWN_SPAN + 25'd2048;
  assign rate_p  = 26'(quality_i) * RATE_SPAN + 26'd2048;
  assign cap_p   = 24'(quality_i) * CAP_SPAN + 24'd2048;
  assign lost_q  = fbqg_pkg::FULL_Q - quality_i;
  assign lod_p   = 14'(lost_q) * 14'd3;

  always_comb begin
    levers_o.spawn_gain      = 13'd614 + spawn_p[24:12];
    levers_o.simulation_rate = 14'd2048 + rate_p[25:12];
    levers_o.cap_gain        = 13'd819 + {1'b0, cap_p[23:12]};
    levers_o.collision_tier  = (quality_i > 13'd3072) ? 2'd3 :
                               (quality_i > 13'd2048) ? 2'd2 :
                               (quality_i > 13'd1024) ? 2'd1 : 2'd0;
    levers_o.feature_tier    = (quality_i > 13'd3276) ? 2'd3 :
                               (quality_i > 13'd2252) ? 2'd2 :
                               (quality_i > 13'd1228) ? 2'd1 : 2'd0;
    levers_o.detail_bias     = lod_p[13:12];
    levers_o.sorting_on      = (quality_i > 13'd1638);
  end

endmodule

`default_nettype wire

### design/frame_budget_quality_governor_top.sv
// ---------------------------------------------------------------------------
// Frame budget quality governor
// Per-frame quality control of CLASS_COUNT importance classes against an
// effect time budget, with per-class lever reporting.
// ---------------------------------------------------------------------------
// One input transaction per frame carries the measured effect time and the
// frame delta. The block is stalled until all CLASS_COUNT result
// transactions (class 0 first, last flag on the final class) have been
// taken. A small sequencer drives one shared 16x16 multiplier for the step
// (adjust_rate * elapsed_time) and both threshold products, then walks the
// classes one per cycle: a search for the class to lower or raise, a pass
// through the lever unit for the old and then the updated quality to build
// the change mask, a scan for the floor flag and the first reduced class,
// and one result per cycle out of the output register while the output is
// not stalled. A pinned frame skips the arithmetic, search and scan and
// goes straight to loading its results. Configuration writes take effect
// at once and should only be issued while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module frame_budget_quality_governor_top #(
  parameter int CLASS_COUNT = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire fbqg_pkg::in_t                     in_data_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output fbqg_pkg::out_t                         out_data_o,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [fbqg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [fbqg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int                IDX_W        = $clog2(CLASS_COUNT);
  localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(CLASS_COUNT - 1);
  localparam logic [3:0]        NONE_REDUCED = 4'(CLASS_COUNT);

  // Configuration registers
  logic [15:0] alloc_time_q;
  logic        pinned_q;
  logic [9:0]  reduce_thr_q;
  logic [9:0]  restore_thr_q;
  logic [15:0] adjust_rate_q;
  logic [12:0] crit_floor_q;

  // Control state
  fbqg_pkg::state_e  state_q, state_d;
  logic [IDX_W-1:0]  idx_q;
  logic              dir_reduce_q;
  logic [12:0]       qual_q [CLASS_COUNT];
  logic              over_q;
  logic              at_floor_q;
  logic [3:0]        first_red_q;
  logic [6:0]        mask_q;
  logic              out_valid_q;

  // Payload registers
  logic [15:0]       measured_q;
  logic [15:0]       elapsed_q;
  logic [12:0]       step_q;
  logic [25:0]       red_q;
  logic [25:0]       res_q;
  logic [12:0]       old_q_q;
  fbqg_pkg::levers_t lv_old_q;
  fbqg_pkg::out_t    out_data_q;

  // Combinational helpers
  logic              in_fire;
  logic              out_fire;
  logic [15:0]       alloc_eff;
  logic [12:0]       floor_eff;
  logic [IDX_W-1:0]  idx_nx;
  logic [12:0]       q_rd;
  logic [12:0]       cls_floor;
  logic [13:0]       lower_lim;
  logic [13:0]       raise_sum;
  logic [12:0]       lower_q;
  logic [12:0]       raise_q;
  logic [12:0]       new_q;
  logic              hit;
  logic              search_end;
  logic [15:0]       mul_a;
  logic [15:0]       mul_b;
  logic [31:0]       prod;
  logic [12:0]       step_sat;
  logic [25:0]       lhs;
  logic              reduce_go;
  logic              restore_go;
  logic [12:0]       lv_in;
  fbqg_pkg::levers_t lv;
  logic [6:0]        mask_new;
  logic [IDX_W-1:0]  out_idx;
  fbqg_pkg::out_t    out_next;

  assign in_stall_o  = (state_q != fbqg_pkg::ST_IDLE);
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_fire    = out_valid_q & ~out_stall_i;

  // Zero allocation counts as one; floor saturates at full quality
  assign alloc_eff = (alloc_time_q == 16'd0) ? 16'd1 : alloc_time_q;
  assign floor_eff = (crit_floor_q > fbqg_pkg::FULL_Q) ? fbqg_pkg::FULL_Q : crit_floor_q;

  assign idx_nx    = idx_q + IDX_W'(1);
  assign q_rd      = qual_q[idx_q];
  assign cls_floor = (idx_q == '0) ? floor_eff : 13'd0;

  // Lower toward the floor, raise toward full
  assign lower_lim = {1'b0, cls_floor} + {1'b0, step_q};
  assign raise_sum = {1'b0, q_rd} + {1'b0, step_q};
  assign lower_q   = ({1'b0, q_rd} >= lower_lim) ? (q_rd - step_q) : cls_floor;
  assign raise_q   = (raise_sum > {1'b0, fbqg_pkg::FULL_Q}) ? fbqg_pkg::FULL_Q
                                                             : raise_sum[12:0];
  assign new_q      = dir_reduce_q ? lower_q : raise_q;
  assign hit        = dir_reduce_q ? (q_rd > cls_floor) : (q_rd < fbqg_pkg::FULL_Q);
  assign search_end = dir_reduce_q ? (idx_q == '0) : (idx_q == LAST_IDX);

  // Shared multiplier
  always_comb begin
    case (state_q)
      fbqg_pkg::ST_MUL_STEP: begin
        mul_a = adjust_rate_q;
        mul_b = elapsed_q;
      end
      fbqg_pkg::ST_MUL_RED: begin
        mul_a = 16'(reduce_thr_q);
        mul_b = alloc_eff;
      end
      default: begin
        mul_a = 16'(restore_thr_q);
        mul_b = alloc_eff;
      end
    endcase
  end

  assign prod     = 32'(mul_a) * 32'(mul_b);
  assign step_sat = (prod[31:16] > 16'(fbqg_pkg::FULL_Q)) ? fbqg_pkg::FULL_Q
                                                          : prod[28:16];

  // Ratio test by cross-multiplication: measured*256 against thr*alloc
  assign lhs        = {2'b00, measured_q, 8'h00};
  assign reduce_go  = (lhs > red_q);
  assign restore_go = ~reduce_go & (lhs < res_q);

  // Lever unit input: old quality, updated quality or the class to report
  always_comb begin
    case (state_q)
      fbqg_pkg::ST_MASK_OLD: lv_in = old_q_q;
      fbqg_pkg::ST_OUT:      lv_in = qual_q[idx_nx];
      default:               lv_in = q_rd;
    endcase
  end

  fbqg_levers u_levers (
    .quality_i (lv_in),
    .levers_o  (lv)
  );

  assign mask_new = {lv.sorting_on      != lv_old_q.sorting_on,
                     lv.detail_bias     != lv_old_q.detail_bias,
                     lv.feature_tier    != lv_old_q.feature_tier,
                     lv.collision_tier  != lv_old_q.collision_tier,
                     lv.cap_gain        != lv_old_q.cap_gain,
                     lv.simulation_rate != lv_old_q.simulation_rate,
                     lv.spawn_gain      != lv_old_q.spawn_gain};

  // Build the result for the class about to be loaded
  assign out_idx = (state_q == fbqg_pkg::ST_OUT) ? idx_nx : idx_q;

  always_comb begin
    out_next.class_index     = 3'(out_idx);
    out_next.spawn_gain      = lv.spawn_gain;
    out_next.simulation_rate = lv.simulation_rate;
    out_next.cap_gain        = lv.cap_gain;
    out_next.collision_tier  = lv.collision_tier;
    out_next.feature_tier    = lv.feature_tier;
    out_next.detail_bias     = lv.detail_bias;
    out_next.sorting_on      = lv.sorting_on;
    out_next.changed_mask    = mask_q;
    out_next.status          = {at_floor_q, over_q};
    out_next.reduced_class   = first_red_q;
    out_next.last            = (out_idx == LAST_IDX);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fbqg_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = pinned_q ? fbqg_pkg::ST_LOAD : fbqg_pkg::ST_MUL_STEP;
        end
      end
      fbqg_pkg::ST_MUL_STEP: state_d = fbqg_pkg::ST_MUL_RED;
      fbqg_pkg::ST_MUL_RED:  state_d = fbqg_pkg::ST_MUL_RES;
      fbqg_pkg::ST_MUL_RES:  state_d = fbqg_pkg::ST_DECIDE;
      fbqg_pkg::ST_DECIDE: begin
        state_d = (reduce_go | restore_go) ? fbqg_pkg::ST_SEARCH : fbqg_pkg::ST_SCAN;
      end
      fbqg_pkg::ST_SEARCH: begin
        if (hit) begin
          state_d = fbqg_pkg::ST_MASK_OLD;
        end else if (search_end) begin
          state_d = fbqg_pkg::ST_SCAN;
        end
      end
      fbqg_pkg::ST_MASK_OLD: state_d = fbqg_pkg::ST_MASK_NEW;
      fbqg_pkg::ST_MASK_NEW: state_d = fbqg_pkg::ST_SCAN;
      fbqg_pkg::ST_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = fbqg_pkg::ST_LOAD;
        end
      end
      fbqg_pkg::ST_LOAD: state_d = fbqg_pkg::ST_OUT;
      fbqg_pkg::ST_OUT: begin
        if (out_fire && (idx_q == LAST_IDX)) begin
          state_d = fbqg_pkg::ST_IDLE;
        end
      end
      default: state_d = fbqg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbqg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_time_q  <= 16'd2048;
      pinned_q      <= 1'b0;
      reduce_thr_q  <= 10'd256;
      restore_thr_q <= 10'd205;
      adjust_rate_q <= 16'd2048;
      crit_floor_q  <= 13'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbqg_pkg::CFG_ALLOCATION_TIME:   alloc_time_q  <= cfg_data_i;
        fbqg_pkg::CFG_PINNED_MODE:       pinned_q      <= cfg_data_i[0];
        fbqg_pkg::CFG_REDUCE_THRESHOLD:  reduce_thr_q  <= cfg_data_i[9:0];
        fbqg_pkg::CFG_RESTORE_THRESHOLD: restore_thr_q <= cfg_data_i[9:0];
        fbqg_pkg::CFG_ADJUST_RATE:       adjust_rate_q <= cfg_data_i;
        fbqg_pkg::CFG_CRITICAL_FLOOR:    crit_floor_q  <= cfg_data_i[12:0];
        default: begin
        end
      endcase
    end
  end

  // Governor state and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      dir_reduce_q <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        qual_q[i] <= fbqg_pkg::FULL_Q;
      end
      over_q       <= 1'b0;
      at_floor_q   <= 1'b0;
      first_red_q  <= NONE_REDUCED;
      mask_q       <= 7'd0;
      out_valid_q  <= 1'b0;
    end else begin
      case (state_q)
        fbqg_pkg::ST_IDLE: begin
          if (in_fire) begin
            idx_q  <= '0;
            over_q <= (in_data_i.measured_time > alloc_eff);
            mask_q <= 7'd0;
            // Restart the scan accumulators; pinned frames hold them
            if (!pinned_q) begin
              at_floor_q  <= 1'b1;
              first_red_q <= NONE_REDUCED;
            end
          end
        end
        fbqg_pkg::ST_DECIDE: begin
          dir_reduce_q <= reduce_go;
          idx_q        <= reduce_go ? LAST_IDX : '0;
        end
        fbqg_pkg::ST_SEARCH: begin
          if (hit) begin
            qual_q[idx_q] <= new_q;
          end else if (search_end) begin
            idx_q <= '0;
          end else begin
            idx_q <= dir_reduce_q ? (idx_q - IDX_W'(1)) : idx_nx;
          end
        end
        fbqg_pkg::ST_MASK_NEW: begin
          mask_q <= mask_new;
          idx_q  <= '0;
        end
        fbqg_pkg::ST_SCAN: begin
          if (q_rd > cls_floor) begin
            at_floor_q <= 1'b0;
          end
          if ((q_rd < fbqg_pkg::FULL_Q) && (first_red_q == NONE_REDUCED)) begin
            first_red_q <= 4'(idx_q);
          end
          idx_q <= (idx_q == LAST_IDX) ? '0 : idx_nx;
        end
        fbqg_pkg::ST_LOAD: begin
          out_valid_q <= 1'b1;
        end
        fbqg_pkg::ST_OUT: begin
          if (out_fire) begin
            if (idx_q == LAST_IDX) begin
              out_valid_q <= 1'b0;
            end else begin
              idx_q <= idx_nx;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      fbqg_pkg::ST_IDLE: begin
        if (in_fire) begin
          measured_q <= in_data_i.measured_time;
          elapsed_q  <= in_data_i.elapsed_time;
        end
      end
      fbqg_pkg::ST_MUL_STEP: step_q <= step_sat;
      fbqg_pkg::ST_MUL_RED:  red_q  <= prod[25:0];
      fbqg_pkg::ST_MUL_RES:  res_q  <= prod[25:0];
      fbqg_pkg::ST_SEARCH: begin
        if (hit) begin
          old_q_q <= q_rd;
        end
      end
      fbqg_pkg::ST_MASK_OLD: lv_old_q <= lv;
      fbqg_pkg::ST_LOAD:     out_data_q <= out_next;
      fbqg_pkg::ST_OUT: begin
        // Advance to the next class once the current transaction is taken
        if (out_fire && (idx_q != LAST_IDX)) begin
          out_data_q <= out_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### dv/tb_frame_budget_quality_governor_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Frame budget quality governor testbench
// Feeds frame ticks through the valid/stall channel and predicts the lever
// results of every class in the tracker below. Each result transaction is
// checked field by field against the oldest prediction. A directed opener
// covers the budget and floor corner cases; random frames follow under
// changing register settings and idling patterns.
// ---------------------------------------------------------------------------

module tb_frame_budget_quality_governor_top;

  localparam int NUM_CLASSES  = 4;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int STALL_LIMIT  = 4000;  // cycles without any transaction
  localparam int GUARD_CYCLES = 4;     // settle time before a register write
  localparam int DRAIN_CYCLES = 40;    // quiet time at the end of the run

  // -------------------------------------------------------------------------
  // Lever tracker: shadow copy of the registers and class qualities, plus
  // the queue of lever results still owed by the block.
  // -------------------------------------------------------------------------
  class frame_lever_tracker;
    logic [15:0] alloc_time;
    logic        pinned;
    logic [9:0]  reduce_thr;
    logic [9:0]  restore_thr;
    logic [15:0] adjust_rate;
    logic [12:0] crit_floor;

    logic [12:0] quality [NUM_CLASSES];
    logic        over_flag;
    logic        at_floor;
    logic [3:0]  first_reduced;

    fbqg_pkg::out_t expected_levers [$];
    int             mismatches;

    function new();
      alloc_time    = 16'd2048;
      pinned        = 1'b0;
      reduce_thr    = 10'd256;
      restore_thr   = 10'd205;
      adjust_rate   = 16'd2048;
      crit_floor    = 13'd1024;
      foreach (quality[c]) quality[c] = fbqg_pkg::FULL_Q;
      over_flag     = 1'b0;
      at_floor      = 1'b0;
      first_reduced = 4'(NUM_CLASSES);
      mismatches    = 0;
    endfunction

    function void set_register(logic [fbqg_pkg::CFG_IDX_W-1:0]  idx,
                               logic [fbqg_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        fbqg_pkg::CFG_ALLOCATION_TIME:   alloc_time  = value;
        fbqg_pkg::CFG_PINNED_MODE:       pinned      = value[0];
        fbqg_pkg::CFG_REDUCE_THRESHOLD:  reduce_thr  = value[9:0];
        fbqg_pkg::CFG_RESTORE_THRESHOLD: restore_thr = value[9:0];
        fbqg_pkg::CFG_ADJUST_RATE:       adjust_rate = value;
        fbqg_pkg::CFG_CRITICAL_FLOOR:    crit_floor  = value[12:0];
        default: ;
      endcase
    endfunction

    // Only the critical class has a floor; clamp it to full quality.
    function logic [12:0] class_floor(int c);
      if (c != 0) return 13'd0;
      return (crit_floor > fbqg_pkg::FULL_Q) ? fbqg_pkg::FULL_Q : crit_floor;
    endfunction

    function fbqg_pkg::levers_t quality_levers(logic [12:0] q);
      fbqg_pkg::levers_t lv;
      int unsigned       qq;
      qq = (q > fbqg_pkg::FULL_Q) ? fbqg_pkg::FULL_Q : q;
      lv.spawn_gain      = 13'(614 + ((3482 * qq + 2048) >> 12));
      lv.simulation_rate = 14'(2048 + ((13312 * qq + 2048) >> 12));
      lv.cap_gain        = 13'(819 + ((3277 * qq + 2048) >> 12));
      lv.collision_tier  = (qq > 3072) ? 2'd3 : (qq > 2048) ? 2'd2 : (qq > 1024) ? 2'd1 : 2'd0;
      lv.feature_tier    = (qq > 3276) ? 2'd3 : (qq > 2252) ? 2'd2 : (qq > 1228) ? 2'd1 : 2'd0;
      lv.detail_bias     = 2'((3 * (4096 - qq)) >> 12);
      lv.sorting_on      = (qq > 1638);
      return lv;
    endfunction

    // Advance the governor by one frame and queue one result per class.
    function void take_frame(fbqg_pkg::in_t frame);
      logic [12:0]       prior [NUM_CLASSES];
      fbqg_pkg::levers_t was, now;
      fbqg_pkg::out_t    res;
      int unsigned       alloc, step;
      longint unsigned   product, demand;
      logic [6:0]        mask;

      alloc     = (alloc_time == 0) ? 1 : alloc_time;
      over_flag = (frame.measured_time > alloc);
      prior     = quality;
      mask      = '0;

      if (!pinned) begin
        product = (longint'(adjust_rate) * frame.elapsed_time) >> 16;
        step    = (product > fbqg_pkg::FULL_Q) ? fbqg_pkg::FULL_Q : int'(product);
        demand  = longint'(frame.measured_time) * 256;

        if (demand > longint'(reduce_thr) * alloc) begin
          // lower the least important class still above its floor
          for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (quality[c] <= class_floor(c)) continue;
            quality[c] = (quality[c] >= class_floor(c) + step) ?
                         13'(quality[c] - step) : class_floor(c);
            break;
          end
        end else if (demand < longint'(restore_thr) * alloc) begin
          // raise the most important class below full
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (quality[c] >= fbqg_pkg::FULL_Q) continue;
            quality[c] = (quality[c] + step > fbqg_pkg::FULL_Q) ?
                         fbqg_pkg::FULL_Q : 13'(quality[c] + step);
            break;
          end
        end

        at_floor      = 1'b1;
        first_reduced = 4'(NUM_CLASSES);
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (quality[c] > class_floor(c)) at_floor = 1'b0;
          if (quality[c] < fbqg_pkg::FULL_Q && first_reduced == NUM_CLASSES)
            first_reduced = 4'(c);
        end

        for (int c = 0; c < NUM_CLASSES; c++) begin
          was = quality_levers(prior[c]);
          now = quality_levers(quality[c]);
          if (was.spawn_gain      != now.spawn_gain)      mask[0] = 1'b1;
          if (was.simulation_rate != now.simulation_rate) mask[1] = 1'b1;
          if (was.cap_gain        != now.cap_gain)        mask[2] = 1'b1;
          if (was.collision_tier  != now.collision_tier)  mask[3] = 1'b1;
          if (was.feature_tier    != now.feature_tier)    mask[4] = 1'b1;
          if (was.detail_bias     != now.detail_bias)     mask[5] = 1'b1;
          if (was.sorting_on      != now.sorting_on)      mask[6] = 1'b1;
        end
      end

      for (int c = 0; c < NUM_CLASSES; c++) begin
        now                 = quality_levers(quality[c]);
        res.class_index     = 3'(c);
        res.spawn_gain      = now.spawn_gain;
        res.simulation_rate = now.simulation_rate;
        res.cap_gain        = now.cap_gain;
        res.collision_tier  = now.collision_tier;
        res.feature_tier    = now.feature_tier;
        res.detail_bias     = now.detail_bias;
        res.sorting_on      = now.sorting_on;
        res.changed_mask    = mask;
        res.status          = {at_floor, over_flag};
        res.reduced_class   = first_reduced;
        res.last            = (c == NUM_CLASSES - 1);
        expected_levers.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_levers(fbqg_pkg::out_t got);
      fbqg_pkg::out_t want;
      if (expected_levers.size() == 0) begin
        $display("%0t: unexpected result for class %0d, expected none actual %h",
                 $time, got.class_index, got);
        mismatches++;
        return;
      end
      want = expected_levers.pop_front();
      compare_field("class_index",     want.class_index,     got.class_index);
      compare_field("spawn_gain",      want.spawn_gain,      got.spawn_gain);
      compare_field("simulation_rate", want.simulation_rate, got.simulation_rate);
      compare_field("cap_gain",        want.cap_gain,        got.cap_gain);
      compare_field("collision_tier",  want.collision_tier,  got.collision_tier);
      compare_field("feature_tier",    want.feature_tier,    got.feature_tier);
      compare_field("detail_bias",     want.detail_bias,     got.detail_bias);
      compare_field("sorting_on",      want.sorting_on,      got.sorting_on);
      compare_field("changed_mask",    want.changed_mask,    got.changed_mask);
      compare_field("status",          want.status,          got.status);
      compare_field("reduced_class",   want.reduced_class,   got.reduced_class);
      compare_field("last",            want.last,            got.last);
    endfunction

    function int pending_count();
      return expected_levers.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Block hookup
  // -------------------------------------------------------------------------
  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  fbqg_pkg::in_t                   in_data_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  fbqg_pkg::out_t                  out_data_o;
  logic                            cfg_we_i;
  logic [fbqg_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fbqg_pkg::CFG_DATA_W-1:0] cfg_data_i;

  frame_budget_quality_governor_top #(
    .CLASS_COUNT(NUM_CLASSES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  frame_lever_tracker board;

  int   sender_idle_pct;
  int   receiver_stall_pct;
  logic long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Note every frame the block takes; the prediction runs at the handshake.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.take_frame(in_data_i);
  end

  // Check every lever result the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.match_levers(out_data_o);
  end

  // Receiver: random stall per cycle, or one long hold-off on request so the
  // block backs up and stalls its input while the sender keeps offering.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold   = 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i = ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Hold until every predicted result has been taken.
  task automatic wait_results_drained();
    while (board.pending_count() != 0) @(negedge clk_i);
  endtask

  // Offer one frame tick; hold it until accepted, then drop valid.
  task automatic send_frame(logic [15:0] measured, logic [15:0] elapsed);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i              = 1'b1;
    in_data_i.measured_time = measured;
    in_data_i.elapsed_time  = elapsed;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Write one register once the block has gone idle.
  task automatic write_reg(logic [fbqg_pkg::CFG_IDX_W-1:0]  idx,
                           logic [fbqg_pkg::CFG_DATA_W-1:0] value);
    wait_results_drained();
    repeat (GUARD_CYCLES) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.set_register(idx, value);
  endtask

  // Pick a fresh setting for every register, extremes included.
  task automatic configure_random();
    logic [15:0] v;
    case ($urandom_range(4))
      0:       v = 16'hFFFF;
      1:       v = 16'd1;
      2:       v = 16'd0;
      default: v = 16'($urandom_range(512, 16384));
    endcase
    write_reg(fbqg_pkg::CFG_ALLOCATION_TIME, v);
    write_reg(fbqg_pkg::CFG_PINNED_MODE, {15'd0, ($urandom_range(4) == 0)});
    case ($urandom_range(4))
      0:       v = 16'd0;
      1:       v = 16'd1023;
      default: v = 16'($urandom_range(230, 400));
    endcase
    write_reg(fbqg_pkg::CFG_REDUCE_THRESHOLD, v);
    case ($urandom_range(4))
      0:       v = 16'd0;
      1:       v = 16'd1023;
      default: v = 16'($urandom_range(100, 250));
    endcase
    write_reg(fbqg_pkg::CFG_RESTORE_THRESHOLD, v);
    case ($urandom_range(4))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(1024, 32768));
    endcase
    write_reg(fbqg_pkg::CFG_ADJUST_RATE, v);
    case ($urandom_range(5))
      0:       v = 16'd0;
      1:       v = 16'd4096;
      2:       v = 16'd8191;
      default: v = 16'($urandom_range(4096));
    endcase
    write_reg(fbqg_pkg::CFG_CRITICAL_FLOOR, v);
  endtask

  // Mostly load ratios around the thresholds so qualities keep moving;
  // some raw and extreme values for the rest.
  function automatic fbqg_pkg::in_t random_frame();
    fbqg_pkg::in_t f;
    int unsigned   base, scaled, pick;
    base = (board.alloc_time == 0) ? 1 : board.alloc_time;
    pick = $urandom_range(99);
    if (pick < 70) begin
      scaled = base * $urandom_range(1100) / 256;
      f.measured_time = (scaled > 65535) ? 16'hFFFF : 16'(scaled);
    end else if (pick < 85) begin
      f.measured_time = 16'($urandom);
    end else begin
      f.measured_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    pick = $urandom_range(99);
    if (pick < 75)      f.elapsed_time = 16'($urandom_range(4000));
    else if (pick < 90) f.elapsed_time = 16'($urandom);
    else                f.elapsed_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return f;
  endfunction

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    fbqg_pkg::in_t f;
    board              = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    long_hold          = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    in_data_i          = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = fbqg_pkg::CFG_ALLOCATION_TIME;
    cfg_data_i         = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed opener under the reset settings.
    send_frame(16'd0, 16'd0);           // raise request with all classes full, zero step
    send_frame(16'hFFFF, 16'hFFFF);     // over budget, lower class 3
    send_frame(16'd2048, 16'hFFFF);     // ratio exactly at reduce threshold: hold
    send_frame(16'd2049, 16'd0);        // lower with zero step
    send_frame(16'd1600, 16'hFFFF);     // just under restore threshold: raise back

    // Saturated step: drive every class down to its floor, then past it.
    write_reg(fbqg_pkg::CFG_ADJUST_RATE, 16'hFFFF);
    repeat (5) send_frame(16'hFFFF, 16'hFFFF);

    // Floor above full: class 0 now sits below its floor and is skipped.
    write_reg(fbqg_pkg::CFG_CRITICAL_FLOOR, 16'd8191);
    send_frame(16'hFFFF, 16'hFFFF);
    write_reg(fbqg_pkg::CFG_CRITICAL_FLOOR, 16'd0);
    send_frame(16'hFFFF, 16'hFFFF);

    // Pinned: only the over-budget flag follows the load.
    write_reg(fbqg_pkg::CFG_PINNED_MODE, 16'd1);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd0, 16'hFFFF);
    write_reg(fbqg_pkg::CFG_PINNED_MODE, 16'd0);

    // Zero allocation is taken as one.
    write_reg(fbqg_pkg::CFG_ALLOCATION_TIME, 16'd0);
    send_frame(16'd1, 16'hFFFF);
    send_frame(16'd2, 16'd100);
    send_frame(16'd0, 16'hFFFF);
    write_reg(fbqg_pkg::CFG_ADJUST_RATE, 16'd2048);
    send_frame(16'd0, 16'd1092);

    // Threshold extremes: neither lowering nor raising can trigger.
    write_reg(fbqg_pkg::CFG_REDUCE_THRESHOLD, 16'd1023);
    write_reg(fbqg_pkg::CFG_RESTORE_THRESHOLD, 16'd0);
    write_reg(fbqg_pkg::CFG_ALLOCATION_TIME, 16'hFFFF);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd0, 16'd0);

    // Random stages: two register settings per idling pattern.
    for (int stage_no = 0; stage_no < 8; stage_no++) begin
      configure_random();
      case (stage_no % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      if (stage_no == 0) long_hold = 1'b1;
      for (int n = 0; n < 26; n++) begin
        // let the block run dry now and then before the next frame
        if (stage_no == 1 && n % 8 == 7) wait_results_drained();
        f = random_frame();
        send_frame(f.measured_time, f.elapsed_time);
      end
    end

    sender_idle_pct = 0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
design/fbqg_pkg.sv
design/fbqg_levers.sv
design/frame_budget_quality_governor_top.sv
dv/tb_frame_budget_quality_governor_top.sv
